/* src/asr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants of the affine scanline texture renderer: item
// opcodes, register indexes and the command passed from front to back.
// ----------------------------------------------------------------------------
package asr_pkg;

   localparam int TEXEL_BITS       = 8;
   localparam int COORD_FRAC_BITS  = 16;
   localparam int COORD_BITS       = 32;
   localparam int DIFF_BITS        = COORD_BITS + 1;
   localparam int TEX_ADDR_BITS    = 20;
   localparam int PIX_WORD_BITS    = 64;
   localparam int PIX_BUS_BITS     = 2 * PIX_WORD_BITS;
   localparam int COUNT_BITS       = 5;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 11;
   localparam int SPAN_CSR_BITS    = 11;
   localparam int DIV_STEPS        = 32;

   localparam logic [SPAN_CSR_BITS-1:0] SPAN_WIDTH_RESET = 11'd320;
   localparam logic [TEXEL_BITS-1:0]    FILL_COLOR_RESET = 8'd15;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPAN_WIDTH = 2'd0,
      CSR_FILL_COLOR = 2'd1
   } csr_index_type;

   typedef struct packed {
      op_type                  op;
      logic [TEX_ADDR_BITS-1:0] tex_addr;
      logic [TEXEL_BITS-1:0]    tex_value;
      logic [DIFF_BITS-1:0]     dx;
      logic [DIFF_BITS-1:0]     dy;
      logic [COORD_BITS-1:0]    mid_x;
      logic [COORD_BITS-1:0]    mid_y;
   } cmd_type;

endpackage
`default_nettype wire

/* src/asr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* src/asr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asr_front
// Input side: takes items, classifies load and render, forms the texel
// address and the endpoint difference and midpoint of a scanline.
// ----------------------------------------------------------------------------
module asr_front #(
   parameter int TEXTURE_SIDE_BITS = 8
) (
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_opcode,
   input  wire logic [7:0]            req_texel_row,
   input  wire logic [7:0]            req_texel_col,
   input  wire logic [7:0]            req_texel_value,
   input  wire logic signed [31:0]    req_left_x,
   input  wire logic signed [31:0]    req_left_y,
   input  wire logic signed [31:0]    req_right_x,
   input  wire logic signed [31:0]    req_right_y,
   output logic                       q_push,
   output asr_pkg::cmd_type           q_data,
   input  wire logic                  q_full
);
   import asr_pkg::*;

   localparam int S = TEXTURE_SIDE_BITS;

   logic [S-1:0]           row_m;
   logic [S-1:0]           col_m;
   logic [DIFF_BITS-1:0]   sum_x;
   logic [DIFF_BITS-1:0]   sum_y;
   logic [DIFF_BITS-1:0]   rnd_x;
   logic [DIFF_BITS-1:0]   rnd_y;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   assign row_m = S'(req_texel_row);
   assign col_m = S'(req_texel_col);

   // midpoint truncated toward zero
   assign sum_x = {req_left_x[31], req_left_x} + {req_right_x[31], req_right_x};
   assign sum_y = {req_left_y[31], req_left_y} + {req_right_y[31], req_right_y};
   assign rnd_x = sum_x + DIFF_BITS'(sum_x[DIFF_BITS-1]);
   assign rnd_y = sum_y + DIFF_BITS'(sum_y[DIFF_BITS-1]);

   always_comb begin
      q_data.op        = op_type'(req_opcode);
      q_data.tex_addr  = TEX_ADDR_BITS'({row_m, col_m});
      q_data.tex_value = req_texel_value;
      q_data.dx        = {req_right_x[31], req_right_x} - {req_left_x[31], req_left_x};
      q_data.dy        = {req_right_y[31], req_right_y} - {req_left_y[31], req_left_y};
      q_data.mid_x     = rnd_x[DIFF_BITS-1:1];
      q_data.mid_y     = rnd_y[DIFF_BITS-1:1];
   end

endmodule
`default_nettype wire

/* src/asr_cmd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asr_cmd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module asr_cmd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  valid
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/asr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asr_back
// Execution side: writes texels, divides the endpoint differences by the
// span width, finds the start point and walks the span one texel per cycle,
// packing pixels in groups behind a result register, stopping while full.
// ----------------------------------------------------------------------------
module asr_back #(
   parameter int MAX_SPAN          = 1024,
   parameter int PIXELS_PER_RESULT = 16,
   parameter int TEXTURE_SIDE_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire asr_pkg::cmd_type                  cmd,
   input  wire logic                              cmd_valid,
   output logic                                   cmd_pop,
   input  wire logic [$clog2(MAX_SPAN+1)-1:0]     span_len,
   input  wire logic [asr_pkg::TEXEL_BITS-1:0]    fill_color,
   output logic                                   ram_we,
   output logic [2*TEXTURE_SIDE_BITS-1:0]         ram_waddr,
   output logic [asr_pkg::TEXEL_BITS-1:0]         ram_wdata,
   output logic [2*TEXTURE_SIDE_BITS-1:0]         ram_raddr,
   input  wire logic [asr_pkg::TEXEL_BITS-1:0]    ram_rdata,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [asr_pkg::PIX_WORD_BITS-1:0]      rsp_pixels_low,
   output logic [asr_pkg::PIX_WORD_BITS-1:0]      rsp_pixels_high,
   output logic [asr_pkg::COUNT_BITS-1:0]         rsp_pixel_count,
   output logic                                   rsp_last_group
);
   import asr_pkg::*;

   localparam int S   = TEXTURE_SIDE_BITS;
   localparam int PPR = PIXELS_PER_RESULT;
   localparam int WW  = $clog2(MAX_SPAN + 1);
   localparam int AW  = COORD_FRAC_BITS + S;
   localparam int GCW = $clog2(PPR + 1);
   localparam int IW  = $clog2(PPR);
   localparam int DCW = $clog2(DIV_STEPS);
   localparam int QB  = COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ADJUST,
      ST_BASE,
      ST_WALK
   } state_type;

   state_type              state_ff, state_in;
   logic [DIFF_BITS-1:0]   dx_ff, dx_in;
   logic [DIFF_BITS-1:0]   dy_ff, dy_in;
   logic [AW-1:0]          mid_x_ff, mid_x_in;
   logic [AW-1:0]          mid_y_ff, mid_y_in;
   logic [QB-1:0]          dvd_x_ff, dvd_x_in;
   logic [QB-1:0]          dvd_y_ff, dvd_y_in;
   logic [WW-1:0]          rem_x_ff, rem_x_in;
   logic [WW-1:0]          rem_y_ff, rem_y_in;
   logic [DCW-1:0]         div_cnt_ff, div_cnt_in;
   logic [DIFF_BITS-1:0]   stepw_x_ff, stepw_x_in;
   logic [DIFF_BITS-1:0]   stepw_y_ff, stepw_y_in;
   logic [AW-1:0]          step_x_ff, step_x_in;
   logic [AW-1:0]          step_y_ff, step_y_in;
   logic                   fill_ff, fill_in;
   logic [AW-1:0]          acc_x_ff, acc_x_in;
   logic [AW-1:0]          acc_y_ff, acc_y_in;
   logic [WW-1:0]          left_ff, left_in;
   logic [GCW-1:0]         gcnt_ff, gcnt_in;
   logic [GCW-1:0]         iss_ff, iss_in;
   logic [GCW-1:0]         rcv_ff, rcv_in;
   logic                   glast_ff, glast_in;
   logic                   pend_ff, pend_in;
   logic [PPR*8-1:0]       buf_ff, buf_in;
   logic                   out_valid_ff, out_valid_in;
   logic [PIX_BUS_BITS-1:0] out_pix_ff, out_pix_in;
   logic [COUNT_BITS-1:0]  out_cnt_ff, out_cnt_in;
   logic                   out_last_ff, out_last_in;

   logic [DIFF_BITS-1:0]   mag_x, mag_y;
   logic [WW:0]            trial_x, trial_y;
   logic                   qbit_x, qbit_y;
   logic [DIFF_BITS-1:0]   half_x, half_y;
   logic                   start_grp;
   logic [WW-1:0]          start_len;
   logic                   grp_small;

   assign ram_waddr = cmd.tex_addr[2*S-1:0];
   assign ram_wdata = cmd.tex_value;
   assign ram_raddr = {acc_y_ff[COORD_FRAC_BITS +: S], acc_x_ff[COORD_FRAC_BITS +: S]};

   assign mag_x   = cmd.dx[DIFF_BITS-1] ? DIFF_BITS'(0) - cmd.dx : cmd.dx;
   assign mag_y   = cmd.dy[DIFF_BITS-1] ? DIFF_BITS'(0) - cmd.dy : cmd.dy;
   assign trial_x = {rem_x_ff, dvd_x_ff[QB-1]};
   assign trial_y = {rem_y_ff, dvd_y_ff[QB-1]};
   assign qbit_x  = (trial_x >= {1'b0, span_len});
   assign qbit_y  = (trial_y >= {1'b0, span_len});
   assign half_x  = stepw_x_ff + DIFF_BITS'(stepw_x_ff[DIFF_BITS-1]);
   assign half_y  = stepw_y_ff + DIFF_BITS'(stepw_y_ff[DIFF_BITS-1]);
   assign grp_small = (32'(start_len) <= 32'(PPR));

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixels_low  = out_pix_ff[PIX_WORD_BITS-1:0];
   assign rsp_pixels_high = out_pix_ff[PIX_BUS_BITS-1:PIX_WORD_BITS];
   assign rsp_pixel_count = out_cnt_ff;
   assign rsp_last_group  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      mid_x_in     = mid_x_ff;
      mid_y_in     = mid_y_ff;
      dvd_x_in     = dvd_x_ff;
      dvd_y_in     = dvd_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      div_cnt_in   = div_cnt_ff;
      stepw_x_in   = stepw_x_ff;
      stepw_y_in   = stepw_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      fill_in      = fill_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      left_in      = left_ff;
      gcnt_in      = gcnt_ff;
      iss_in       = iss_ff;
      rcv_in       = rcv_ff;
      glast_in     = glast_ff;
      pend_in      = 1'b0;
      buf_in       = buf_ff;
      out_valid_in = out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      start_grp    = 1'b0;
      start_len    = span_len;

      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  dx_in      = cmd.dx;
                  dy_in      = cmd.dy;
                  mid_x_in   = cmd.mid_x[AW-1:0];
                  mid_y_in   = cmd.mid_y[AW-1:0];
                  dvd_x_in   = mag_x[QB-1:0];
                  dvd_y_in   = mag_y[QB-1:0];
                  rem_x_in   = '0;
                  rem_y_in   = '0;
                  div_cnt_in = '0;
                  state_in   = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            // one restoring step per cycle on both axes
            rem_x_in   = qbit_x ? WW'(trial_x - {1'b0, span_len}) : WW'(trial_x);
            rem_y_in   = qbit_y ? WW'(trial_y - {1'b0, span_len}) : WW'(trial_y);
            dvd_x_in   = {dvd_x_ff[QB-2:0], qbit_x};
            dvd_y_in   = {dvd_y_ff[QB-2:0], qbit_y};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCW'(DIV_STEPS - 1)) begin
               state_in = ST_ADJUST;
            end
         end
         ST_ADJUST: begin
            // step*width equals the difference less the signed remainder
            stepw_x_in = dx_ff[DIFF_BITS-1] ? dx_ff + DIFF_BITS'(rem_x_ff)
                                            : dx_ff - DIFF_BITS'(rem_x_ff);
            stepw_y_in = dy_ff[DIFF_BITS-1] ? dy_ff + DIFF_BITS'(rem_y_ff)
                                            : dy_ff - DIFF_BITS'(rem_y_ff);
            step_x_in  = dx_ff[DIFF_BITS-1] ? AW'(0) - dvd_x_ff[AW-1:0] : dvd_x_ff[AW-1:0];
            step_y_in  = dy_ff[DIFF_BITS-1] ? AW'(0) - dvd_y_ff[AW-1:0] : dvd_y_ff[AW-1:0];
            fill_in    = (dvd_x_ff == '0) && (dvd_y_ff == '0);
            state_in   = ST_ADJUST == ST_ADJUST ? ST_BASE : ST_BASE;
         end
         ST_BASE: begin
            acc_x_in  = mid_x_ff - half_x[AW:1];
            acc_y_in  = mid_y_ff - half_y[AW:1];
            start_grp = 1'b1;
            start_len = span_len;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (iss_ff != gcnt_ff) begin
               acc_x_in = acc_x_ff + step_x_ff;
               acc_y_in = acc_y_ff + step_y_ff;
               iss_in   = iss_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               buf_in[{rcv_ff[IW-1:0], 3'b000} +: 8] = fill_ff ? fill_color : ram_rdata;
               rcv_in = rcv_ff + 1'b1;
            end
            if ((rcv_ff == gcnt_ff) && !out_valid_ff) begin
               out_valid_in = 1'b1;
               out_pix_in   = PIX_BUS_BITS'(buf_ff);
               out_cnt_in   = COUNT_BITS'(gcnt_ff);
               out_last_in  = glast_ff;
               if (glast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  start_grp = 1'b1;
                  start_len = left_ff - WW'(gcnt_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start_grp) begin
         left_in  = start_len;
         gcnt_in  = grp_small ? GCW'(start_len) : GCW'(PPR);
         glast_in = grp_small;
         iss_in   = '0;
         rcv_in   = '0;
         buf_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      mid_x_ff   <= mid_x_in;
      mid_y_ff   <= mid_y_in;
      dvd_x_ff   <= dvd_x_in;
      dvd_y_ff   <= dvd_y_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      div_cnt_ff <= div_cnt_in;
      stepw_x_ff <= stepw_x_in;
      stepw_y_ff <= stepw_y_in;
      step_x_ff  <= step_x_in;
      step_y_ff  <= step_y_in;
      fill_ff    <= fill_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      left_ff    <= left_in;
      gcnt_ff    <= gcnt_in;
      iss_ff     <= iss_in;
      rcv_ff     <= rcv_in;
      glast_ff   <= glast_in;
      buf_ff     <= buf_in;
      out_pix_ff <= out_pix_in;
      out_cnt_ff <= out_cnt_in;
      out_last_ff <= out_last_in;
   end

endmodule
`default_nettype wire

/* src/affine_scanline_texture_render.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// affine_scanline_texture_render
// Mode-7 style scanline renderer over a square byte texture.
// ----------------------------------------------------------------------------
// A load item writes one texel in the cycle it is dequeued. A render item
// divides the endpoint differences by the span width in a bit-serial
// divider, adjusts the results to signed steps, finds the start point, then
// walks the span at one texture read per cycle through the single read port
// of the texture RAM, pausing between groups while the result register is
// still full. Pixels come out in groups of up to PIXELS_PER_RESULT. A
// two-entry command queue takes new items while a render runs; the user
// must write span_width and fill_color only while the block is idle, and the
// block itself does not enforce it. The texture has no reset and must be
// written before it is read.
// ----------------------------------------------------------------------------
module affine_scanline_texture_render #(
   parameter int MAX_SPAN          = 1024,
   parameter int PIXELS_PER_RESULT = 16,
   parameter int TEXTURE_SIDE_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [asr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [asr_pkg::CSR_DATA_BITS-1:0]      csr_write_data,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic                                   req_opcode,
   input  wire logic [7:0]                             req_texel_row,
   input  wire logic [7:0]                             req_texel_col,
   input  wire logic [7:0]                             req_texel_value,
   input  wire logic signed [31:0]                     req_left_x,
   input  wire logic signed [31:0]                     req_left_y,
   input  wire logic signed [31:0]                     req_right_x,
   input  wire logic signed [31:0]                     req_right_y,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic [63:0]                                 rsp_pixels_low,
   output logic [63:0]                                 rsp_pixels_high,
   output logic [4:0]                                  rsp_pixel_count,
   output logic                                        rsp_last_group
);
   import asr_pkg::*;

   localparam int S         = TEXTURE_SIDE_BITS;
   localparam int WW        = $clog2(MAX_SPAN + 1);
   localparam int CMD_BITS  = $bits(cmd_type);
   localparam int TEX_DEPTH = 1 << (2 * S);

   logic [SPAN_CSR_BITS-1:0] span_ff, span_in;
   logic [TEXEL_BITS-1:0]    fill_ff, fill_in;
   logic [31:0]              span_masked;
   logic [31:0]              span_clamped;
   logic [WW-1:0]            span_len;

   cmd_type                  front_cmd;
   logic                     front_push;
   logic                     q_full;
   logic [CMD_BITS-1:0]      q_head;
   logic                     q_valid;
   logic                     q_pop;
   cmd_type                  back_cmd;

   logic                     ram_we;
   logic [2*S-1:0]           ram_waddr;
   logic [TEXEL_BITS-1:0]    ram_wdata;
   logic [2*S-1:0]           ram_raddr;
   logic [TEXEL_BITS-1:0]    ram_rdata;

   always_comb begin
      span_in = span_ff;
      fill_in = fill_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SPAN_WIDTH: span_in = csr_write_data[SPAN_CSR_BITS-1:0];
            CSR_FILL_COLOR: fill_in = csr_write_data[TEXEL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= SPAN_WIDTH_RESET;
         fill_ff <= FILL_COLOR_RESET;
      end else begin
         span_ff <= span_in;
         fill_ff <= fill_in;
      end
   end

   // width rounded down to a multiple of four and clamped to the span range
   assign span_masked  = 32'({span_ff[SPAN_CSR_BITS-1:2], 2'b00});
   assign span_clamped = (span_masked < 32'd4) ? 32'd4
                       : (span_masked > 32'(MAX_SPAN)) ? 32'(MAX_SPAN) : span_masked;
   assign span_len     = WW'(span_clamped);

   asr_front #(
      .TEXTURE_SIDE_BITS(TEXTURE_SIDE_BITS)
   ) u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_texel_row  (req_texel_row),
      .req_texel_col  (req_texel_col),
      .req_texel_value(req_texel_value),
      .req_left_x     (req_left_x),
      .req_left_y     (req_left_y),
      .req_right_x    (req_right_x),
      .req_right_y    (req_right_y),
      .q_push         (front_push),
      .q_data         (front_cmd),
      .q_full         (q_full)
   );

   asr_cmd_queue #(
      .WIDTH(CMD_BITS),
      .DEPTH(2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_head),
      .valid    (q_valid)
   );

   assign back_cmd = cmd_type'(q_head);

   asr_ram #(
      .WIDTH(TEXEL_BITS),
      .DEPTH(TEX_DEPTH)
   ) u_texture (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   asr_back #(
      .MAX_SPAN         (MAX_SPAN),
      .PIXELS_PER_RESULT(PIXELS_PER_RESULT),
      .TEXTURE_SIDE_BITS(TEXTURE_SIDE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (back_cmd),
      .cmd_valid      (q_valid),
      .cmd_pop        (q_pop),
      .span_len       (span_len),
      .fill_color     (fill_ff),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixels_low (rsp_pixels_low),
      .rsp_pixels_high(rsp_pixels_high),
      .rsp_pixel_count(rsp_pixel_count),
      .rsp_last_group (rsp_last_group)
   );

endmodule
`default_nettype wire
